### src/motion_intensity_tracker_macros.svh
// Assertion macros shared by the motion intensity tracker RTL.
`ifndef MOTION_INTENSITY_TRACKER_MACROS_SVH
`define MOTION_INTENSITY_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mit_pkg.sv
// Shared types, constants and helpers of the motion intensity tracker.
package mit_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 2'd1;

	localparam logic [15:0] HALF_LENGTH_RST = 16'd32768;
	localparam logic [15:0] DECAY_NUM       = 16'd65470;

	// Operand widths of the shared multiplier and compare-subtract unit
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int CSU_W   = 32;

	typedef struct packed {
		logic             ge;
		logic [CSU_W-1:0] diff;
	} csu_res_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] x);
		logic [15:0] r;
		r = x[15] ? (~x + 16'd1) : x;
		return r;
	endfunction

endpackage

### src/mit_mul.sv
// Registered unsigned multiplier shared by all products of the tracker.
module mit_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [mit_pkg::MUL_A_W-1:0]  a,
	input  logic [mit_pkg::MUL_B_W-1:0]  b,
	output logic [mit_pkg::MUL_P_W-1:0]  p
);

	logic [mit_pkg::MUL_P_W-1:0] p_q;

	// hold the product until the next issue
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= mit_pkg::MUL_P_W'(a) * mit_pkg::MUL_P_W'(b);
		end
	end

	assign p = p_q;

endmodule

### src/mit_csu.sv
// Compare-subtract unit used by the square root and division steps.
module mit_csu (
	input  logic [mit_pkg::CSU_W-1:0] a,
	input  logic [mit_pkg::CSU_W-1:0] b,
	output mit_pkg::csu_res_t         res
);

	always_comb begin
		res.ge   = (a >= b);
		res.diff = a - b;
	end

endmodule

### src/motion_intensity_tracker.sv
// Top level of the motion intensity tracker: sequencer, state and output register.
//
// Usage: the input channel (in_valid/in_ready) takes one IMU sample. in_ready is high
// only while the sequencer is idle. The output channel (out_valid/out_ready) gives one
// result item per sample, held in an output register until taken. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready: index 0 writes
// enable, index 1 writes half_length, other indexes are ignored.
// Steps: an enabled sample runs through six product steps and one sum step, 16 square
// root steps on the shared compare-subtract unit, one update step, three divisions of
// one load and eight steps each, and the output step; the sequencer then returns to idle.
// A sample taken while disabled goes straight from idle to the output step and shows up
// with updated low. No new sample is taken before the sequencer is back in idle.
// Reset: enable is 1, half_length is 32768, all peaks and previous values are zero,
// and no result is pending.
// Stall: while the output register holds an untaken item and out_ready is low, the
// finished result waits in the last sequencer step, and no new sample is taken meanwhile.
`include "motion_intensity_tracker_macros.svh"

module motion_intensity_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mit_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mit_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  gyro_x,
	input  logic signed [15:0]                  gyro_y,
	input  logic signed [15:0]                  gyro_z,
	input  logic signed [15:0]                  accel_x,
	input  logic signed [15:0]                  accel_y,
	input  logic signed [15:0]                  accel_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                updated,
	output logic [16:0]                         angular_speed,
	output logic [7:0]                          relative_angular_speed,
	output logic [16:0]                         angular_accel,
	output logic [7:0]                          relative_angular_accel,
	output logic [15:0]                         accel_magnitude,
	output logic [15:0]                         jerk_value,
	output logic [7:0]                          relative_jerk,
	output logic signed [15:0]                  axial_accel,
	output logic [31:0]                         centripetal
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MSQ  = 4'd1;
	localparam logic [3:0] S_MCL  = 4'd2;
	localparam logic [3:0] S_MCH  = 4'd3;
	localparam logic [3:0] S_MAX  = 4'd4;
	localparam logic [3:0] S_MAY  = 4'd5;
	localparam logic [3:0] S_MAZ  = 4'd6;
	localparam logic [3:0] S_MSUM = 4'd7;
	localparam logic [3:0] S_SQRT = 4'd8;
	localparam logic [3:0] S_PREP = 4'd9;
	localparam logic [3:0] S_DLD  = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	localparam logic [1:0] SEL_SPEED = 2'd0;
	localparam logic [1:0] SEL_ANG   = 2'd1;
	localparam logic [1:0] SEL_JERK  = 2'd2;

	function automatic logic [31:0] times255(input logic [24:0] v);
		logic [32:0] t;
		t = {v, 8'd0} - {8'd0, v};
		return t[31:0];
	endfunction

	// configuration
	logic        enable_q;
	logic [15:0] half_length_q;

	// sequencer
	logic [3:0] state_q;
	logic [3:0] cnt_q;
	logic [1:0] sel_q;
	logic       upd_q;

	// sample and intermediate values
	logic [16:0]        speed_q;
	logic [15:0]        axa_q;
	logic [15:0]        aya_q;
	logic [15:0]        aza_q;
	logic signed [15:0] ay_raw_q;
	logic [7:0]         sq_q;
	logic [40:0]        cacc_q;
	logic [31:0]        cent_q;
	logic [31:0]        sum_q;
	logic [17:0]        rem_q;
	logic [15:0]        root_q;
	logic [16:0]        ang_q;
	logic [15:0]        jerk_q;
	logic [31:0]        dr_q;
	logic [7:0]         quo_q;
	logic [7:0]         rel_spd_q;
	logic [7:0]         rel_ang_q;
	logic [7:0]         rel_jerk_q;

	// tracker state
	logic [15:0] prev_mag_q;
	logic [16:0] prev_speed_q;
	logic [15:0] peak_jerk_q;
	logic [16:0] peak_ang_q;
	logic [24:0] peak_speed_q;

	// output register
	logic               out_valid_q;
	logic               o_updated_q;
	logic [16:0]        o_speed_q;
	logic [7:0]         o_rel_speed_q;
	logic [16:0]        o_ang_q;
	logic [7:0]         o_rel_ang_q;
	logic [15:0]        o_mag_q;
	logic [15:0]        o_jerk_q;
	logic [7:0]         o_rel_jerk_q;
	logic signed [15:0] o_axial_q;
	logic [31:0]        o_cent_q;

	// shared units
	logic                                mul_en;
	logic [mit_pkg::MUL_A_W-1:0]         mul_a;
	logic [mit_pkg::MUL_B_W-1:0]         mul_b;
	logic [mit_pkg::MUL_P_W-1:0]         mul_p;
	logic [mit_pkg::CSU_W-1:0]           csu_a;
	logic [mit_pkg::CSU_W-1:0]           csu_b;
	mit_pkg::csu_res_t                   csu_res;

	logic [16:0] speed_in;
	logic [24:0] speed_q8;
	logic [24:0] peak_speed_new;
	logic [16:0] ang_new;
	logic [15:0] jerk_new;
	logic [31:0] div_n;
	logic [31:0] div_d;
	logic [48:0] cent_tot;
	logic        out_load;

	mit_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	mit_csu u_csu (
		.a   (csu_a),
		.b   (csu_b),
		.res (csu_res)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign speed_in  = {1'b0, mit_pkg::abs16(gyro_x)} + {1'b0, mit_pkg::abs16(gyro_z)};
	assign speed_q8  = {speed_q, 8'd0};
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign cent_tot  = {mul_p[23:0], 25'd0} + {8'd0, cacc_q};

	always_comb begin
		peak_speed_new = (speed_q8 > peak_speed_q) ? speed_q8 : peak_speed_q;
		ang_new  = (speed_q > prev_speed_q) ? (speed_q - prev_speed_q)
		                                    : (prev_speed_q - speed_q);
		jerk_new = (root_q > prev_mag_q) ? (root_q - prev_mag_q) : (prev_mag_q - root_q);
	end

	// dividend and divisor of the current relative figure
	always_comb begin
		case (sel_q)
			SEL_SPEED: begin
				div_n = times255(speed_q8);
				div_d = {7'd0, peak_speed_q};
			end
			SEL_ANG: begin
				div_n = times255({8'd0, ang_q});
				div_d = {15'd0, peak_ang_q};
			end
			SEL_JERK: begin
				div_n = times255({9'd0, jerk_q});
				div_d = {16'd0, peak_jerk_q};
			end
			default: begin
				div_n = '0;
				div_d = '0;
			end
		endcase
	end

	// multiplier operands per sequencer step
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_MSQ: begin
				mul_a = {8'd0, speed_q};
				mul_b = speed_q;
			end
			S_MCL: begin
				mul_a = mul_p[24:0];
				mul_b = {1'b0, half_length_q};
			end
			S_MCH: begin
				mul_a = {17'd0, sq_q};
				mul_b = {1'b0, half_length_q};
			end
			S_MAX: begin
				mul_a = {9'd0, axa_q};
				mul_b = {1'b0, axa_q};
			end
			S_MAY: begin
				mul_a = {9'd0, aya_q};
				mul_b = {1'b0, aya_q};
			end
			S_MAZ: begin
				mul_a = {9'd0, aza_q};
				mul_b = {1'b0, aza_q};
			end
			S_PREP: begin
				mul_a = peak_speed_new;
				mul_b = {1'b0, mit_pkg::DECAY_NUM};
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// compare-subtract operands: root digit trial or shifted divisor
	always_comb begin
		if (state_q == S_SQRT) begin
			csu_a = {12'd0, rem_q, sum_q[31:30]};
			csu_b = {14'd0, root_q, 2'b01};
		end else begin
			csu_a = dr_q;
			csu_b = div_d << cnt_q[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			half_length_q <= mit_pkg::HALF_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mit_pkg::REG_ENABLE:      enable_q      <= cfg_data[0];
				mit_pkg::REG_HALF_LENGTH: half_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			sel_q        <= SEL_SPEED;
			upd_q        <= 1'b0;
			prev_mag_q   <= '0;
			prev_speed_q <= '0;
			peak_jerk_q  <= '0;
			peak_ang_q   <= '0;
			peak_speed_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						upd_q   <= enable_q;
						state_q <= enable_q ? S_MSQ : S_OUT;
					end
				end
				S_MSQ:  state_q <= S_MCL;
				S_MCL:  state_q <= S_MCH;
				S_MCH:  state_q <= S_MAX;
				S_MAX:  state_q <= S_MAY;
				S_MAY:  state_q <= S_MAZ;
				S_MAZ:  state_q <= S_MSUM;
				S_MSUM: begin
					cnt_q   <= 4'd15;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					prev_mag_q   <= root_q;
					prev_speed_q <= speed_q;
					peak_speed_q <= peak_speed_new;
					if (jerk_new > peak_jerk_q) begin
						peak_jerk_q <= jerk_new;
					end
					if (ang_new > peak_ang_q) begin
						peak_ang_q <= ang_new;
					end
					sel_q   <= SEL_SPEED;
					state_q <= S_DLD;
				end
				S_DLD: begin
					cnt_q   <= 4'd7;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						sel_q   <= sel_q + 2'd1;
						state_q <= (sel_q == SEL_JERK) ? S_OUT : S_DLD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						// apply the speed peak decay when the item is loaded into the output register
						if (upd_q) begin
							peak_speed_q <= mul_p[40:16];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				speed_q  <= speed_in;
				axa_q    <= mit_pkg::abs16(accel_x);
				aya_q    <= mit_pkg::abs16(accel_y);
				aza_q    <= mit_pkg::abs16(accel_z);
				ay_raw_q <= accel_y;
			end
			S_MCL: sq_q   <= mul_p[32:25];
			S_MCH: cacc_q <= mul_p[40:0];
			S_MAX: cent_q <= cent_tot[47:16];
			S_MAY: sum_q  <= mul_p[31:0];
			S_MAZ: sum_q  <= sum_q + mul_p[31:0];
			S_MSUM: begin
				sum_q  <= sum_q + mul_p[31:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				sum_q <= {sum_q[29:0], 2'b00};
				if (csu_res.ge) begin
					rem_q  <= csu_res.diff[17:0];
					root_q <= {root_q[14:0], 1'b1};
				end else begin
					rem_q  <= csu_a[17:0];
					root_q <= {root_q[14:0], 1'b0};
				end
			end
			S_PREP: begin
				ang_q  <= ang_new;
				jerk_q <= jerk_new;
			end
			S_DLD: begin
				dr_q  <= div_n;
				quo_q <= '0;
			end
			S_DIV: begin
				if (csu_res.ge) begin
					dr_q <= csu_res.diff;
				end
				quo_q[cnt_q[2:0]] <= csu_res.ge;
				if (cnt_q == 4'd0) begin
					// a zero peak gives zero
					case (sel_q)
						SEL_SPEED: rel_spd_q  <= (div_d == '0) ? 8'd0 : {quo_q[7:1], csu_res.ge};
						SEL_ANG:   rel_ang_q  <= (div_d == '0) ? 8'd0 : {quo_q[7:1], csu_res.ge};
						default:   rel_jerk_q <= (div_d == '0) ? 8'd0 : {quo_q[7:1], csu_res.ge};
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// disabled items deliver all-zero fields
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_updated_q   <= upd_q;
			o_speed_q     <= upd_q ? speed_q : '0;
			o_rel_speed_q <= upd_q ? rel_spd_q : '0;
			o_ang_q       <= upd_q ? ang_q : '0;
			o_rel_ang_q   <= upd_q ? rel_ang_q : '0;
			o_mag_q       <= upd_q ? prev_mag_q : '0;
			o_jerk_q      <= upd_q ? jerk_q : '0;
			o_rel_jerk_q  <= upd_q ? rel_jerk_q : '0;
			o_axial_q     <= upd_q ? ay_raw_q : '0;
			o_cent_q      <= upd_q ? cent_q : '0;
		end
	end

	assign out_valid              = out_valid_q;
	assign updated                = o_updated_q;
	assign angular_speed          = o_speed_q;
	assign relative_angular_speed = o_rel_speed_q;
	assign angular_accel          = o_ang_q;
	assign relative_angular_accel = o_rel_ang_q;
	assign accel_magnitude        = o_mag_q;
	assign jerk_value             = o_jerk_q;
	assign relative_jerk          = o_rel_jerk_q;
	assign axial_accel            = o_axial_q;
	assign centripetal            = o_cent_q;

	`MIT_ASSERT_NEXT(a_disabled_skips, (in_valid && in_ready && !enable_q), (state_q == S_OUT), "disabled item did not go straight to output")
	`MIT_ASSERT_NOW(a_div_fits, (state_q == S_DIV), ((div_d == 32'd0) || (33'(dr_q) < (33'(div_d) << (4'(cnt_q[2:0]) + 4'd1)))), "division remainder out of range")
	`MIT_ASSERT_NOW(a_out_from_seq, $rose(out_valid_q), $past(state_q == S_OUT), "result appeared outside the output step")
	`MIT_ASSERT_NEXT(a_peak_grows, (state_q == S_PREP), (peak_speed_q >= $past(peak_speed_q)), "speed peak dropped at update")

endmodule
